### hw/rtl/mce_pkg.sv
// shared types and codes for the midi channel message encoder
`default_nettype none

package mce_pkg;

    localparam logic [2:0] ACT_NOTE_ON     = 3'd0;
    localparam logic [2:0] ACT_NOTE_OFF    = 3'd1;
    localparam logic [2:0] ACT_PITCH_BEND  = 3'd2;
    localparam logic [2:0] ACT_CONTROLLER  = 3'd3;
    localparam logic [2:0] ACT_PROGRAM     = 3'd4;
    localparam logic [2:0] ACT_PRESSURE    = 3'd5;
    localparam logic [2:0] ACT_END_TRACK   = 3'd6;
    localparam logic [2:0] ACT_TRACK_START = 3'd7;

    localparam int MAX_BYTES = 7;

    typedef struct packed {
        logic [2:0]  action;
        logic [27:0] delta_ticks;
        logic [3:0]  channel;
        logic [6:0]  data_a;
        logic [6:0]  data_b;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // one encoded event: first byte in the low slot
    typedef struct packed {
        logic [2:0]             count;
        logic [8*MAX_BYTES-1:0] bytes;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_chan;

endpackage

`default_nettype wire

### hw/rtl/mce_front.sv
// front end: classifies events, tracks running status, builds the byte list
`default_nettype none

module mce_front
    import mce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_data,
    input  wire logic      i_accept,
    input  wire t_in_item  i_item,
    output t_cmd_chan      o_chan
);

    logic       r_no_rs;
    logic [8:0] r_last_status;
    logic [8:0] n_last_status;

    logic [3:0]  status_hi;
    logic [7:0]  status;
    logic [2:0]  groups;
    logic [31:0] vlq_bytes;
    logic [23:0] tail;
    logic [2:0]  tail_cnt;
    logic        two_data;
    logic        send_status;
    logic [27:0] d;

    assign d = i_item.delta_ticks;

    always_comb begin
        unique case (i_item.action)
            ACT_NOTE_ON:    status_hi = 4'h9;
            ACT_NOTE_OFF:   status_hi = 4'h8;
            ACT_PITCH_BEND: status_hi = 4'hE;
            ACT_CONTROLLER: status_hi = 4'hB;
            ACT_PROGRAM:    status_hi = 4'hC;
            ACT_PRESSURE:   status_hi = 4'hD;
            default:        status_hi = 4'h0;
        endcase
    end

    assign status      = {status_hi, i_item.channel};
    assign two_data    = (i_item.action != ACT_PROGRAM) && (i_item.action != ACT_PRESSURE);
    assign send_status = r_no_rs || (r_last_status != {1'b1, status});

    // number of 7-bit groups in the delta, at least one
    always_comb begin
        if (|d[27:21]) begin
            groups = 3'd4;
        end else if (|d[20:14]) begin
            groups = 3'd3;
        end else if (|d[13:7]) begin
            groups = 3'd2;
        end else begin
            groups = 3'd1;
        end
    end

    always_comb begin
        case (groups)
            3'd1:    vlq_bytes = {24'h0, 1'b0, d[6:0]};
            3'd2:    vlq_bytes = {16'h0, 1'b0, d[6:0], 1'b1, d[13:7]};
            3'd3:    vlq_bytes = {8'h0, 1'b0, d[6:0], 1'b1, d[13:7], 1'b1, d[20:14]};
            default: vlq_bytes = {1'b0, d[6:0], 1'b1, d[13:7], 1'b1, d[20:14],
                                  1'b1, d[27:21]};
        endcase
    end

    always_comb begin
        if (send_status) begin
            tail     = two_data ? {1'b0, i_item.data_b, 1'b0, i_item.data_a, status}
                                : {8'h0, 1'b0, i_item.data_a, status};
            tail_cnt = two_data ? 3'd3 : 3'd2;
        end else begin
            tail     = two_data ? {8'h0, 1'b0, i_item.data_b, 1'b0, i_item.data_a}
                                : {16'h0, 1'b0, i_item.data_a};
            tail_cnt = two_data ? 3'd2 : 3'd1;
        end
    end

    always_comb begin
        o_chan.valid = i_accept && (i_item.action != ACT_TRACK_START);
        if (i_item.action == ACT_END_TRACK) begin
            o_chan.cmd.count = 3'd4;
            o_chan.cmd.bytes = {24'h0, 8'h00, 8'h2F, 8'hFF, 8'h01};
        end else begin
            o_chan.cmd.count = groups + tail_cnt;
            o_chan.cmd.bytes = {24'h0, vlq_bytes}
                             | ({32'h0, tail} << {groups, 3'b000});
        end
    end

    always_comb begin
        n_last_status = r_last_status;
        if (i_accept) begin
            if (i_item.action == ACT_END_TRACK || i_item.action == ACT_TRACK_START) begin
                n_last_status = 9'h000;
            end else if (send_status) begin
                n_last_status = {1'b1, status};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_rs       <= 1'b0;
            r_last_status <= 9'h000;
        end else begin
            r_last_status <= n_last_status;
            if (i_cfg_we) begin
                r_no_rs <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mce_queue.sv
// two-entry queue of encoded events between front and back
`default_nettype none

module mce_queue
    import mce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_chan i_wr,
    input  wire logic      i_rd,
    output logic           o_full,
    output t_cmd_chan      o_rd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_wr;
    logic       do_rd;

    assign o_full       = (r_cnt == 2'd2);
    assign o_rd.valid   = (r_cnt != 2'd0);
    assign o_rd.cmd     = r_mem[r_rp];
    assign do_wr        = i_wr.valid && !o_full;
    assign do_rd        = i_rd && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wp <= ~r_wp;
            end
            if (do_rd) begin
                r_rp <= ~r_rp;
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mce_back.sv
// back end: shifts encoded bytes out one per transaction
`default_nettype none

module mce_back
    import mce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd_chan i_cmd,
    output logic           o_take,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_out_item      o_result
);

    logic [8*MAX_BYTES-1:0] r_bytes;
    logic [2:0]             r_left;
    logic                   popped;

    assign o_empty         = (r_left == 3'd0);
    assign o_result.out_byte = r_bytes[7:0];
    assign o_result.last   = (r_left == 3'd1);
    assign popped          = i_pop && !o_empty;
    // reload when idle or when the final byte of the current event leaves
    assign o_take          = i_cmd.valid && (o_empty || (popped && o_result.last));

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_bytes <= i_cmd.cmd.bytes;
        end else if (popped) begin
            r_bytes <= {8'h00, r_bytes[8*MAX_BYTES-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (o_take) begin
            r_left <= i_cmd.cmd.count;
        end else if (popped) begin
            r_left <= r_left - 3'd1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/midi_channel_message_encoder.sv
// top level of the midi channel message encoder (smf track bytes, running status)
//
//   channel   dir  handshake           payload
//   input     in   i_push / o_full     i_item   (t_in_item)
//   result    out  o_empty / i_pop     o_result (t_out_item)
//   config    in   i_cfg_we            i_cfg_data (no_running_status)
//
// an event leaves as 2 to 7 bytes, one per cycle while i_pop is asserted;
// the back end byte shifter sets that rate, the front end takes an event every cycle
// while the two-entry queue has room. track start events produce no bytes.
// with the back end idle an accepted event is queued, then loaded into the shifter.
// reset clears running status, the config register and the queue.
`default_nettype none

module midi_channel_message_encoder
    import mce_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_data,
    input  wire logic      i_push,
    output logic           o_full,
    input  wire t_in_item  i_item,
    output logic           o_empty,
    input  wire logic      i_pop,
    output t_out_item      o_result
);

    t_cmd_chan front_chan;
    t_cmd_chan queue_chan;
    logic      take;
    logic      in_accept;

    assign in_accept = i_push && !o_full;

    mce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_item     (i_item),
        .o_chan     (front_chan)
    );

    mce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_chan),
        .i_rd    (take),
        .o_full  (o_full),
        .o_rd    (queue_chan)
    );

    mce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_chan),
        .o_take   (take),
        .i_pop    (i_pop),
        .o_empty  (o_empty),
        .o_result (o_result)
    );

    // a byte that is not the last of its event is always followed by another
    a_more_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_result.last) |=> !o_empty)
        else $error("event cut short");

    // track start never reaches the queue
    a_track_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_item.action == ACT_TRACK_START) |-> !front_chan.valid)
        else $error("track start produced bytes");

    // every queued event has between two and seven bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_chan.valid |-> (front_chan.cmd.count >= 3'd2))
        else $error("bad byte count");

    // an accepted event that emits bytes has output waiting after the queue and shifter registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_chan.valid && in_accept) |-> ##2 !o_empty)
        else $error("output missing after accept");

endmodule

`default_nettype wire
